/* hw/rtl/jpp_pkg.sv */
// Package for the JSON pretty printer: constants, character codes, types and helpers.
package jpp_pkg;

   localparam int unsigned DEPTH_W = 4;
   localparam int unsigned CNT_W   = DEPTH_W + 1;

   localparam logic [DEPTH_W-1:0] MAX_DEPTH = 4'd15;

   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NL2,
      ST_PRE_NL,
      ST_PRE_SP,
      ST_BYTE,
      ST_POST_SP,
      ST_POST_NL,
      ST_POST_IND,
      ST_EOT_NL,
      ST_EOT_IND
   } state_type;

   // Which character the output register takes.
   typedef enum logic [1:0] {
      SEL_NL,
      SEL_SPACE,
      SEL_BYTE
   } emit_sel_type;

   // Output phases that one transaction needs, in emission order.
   typedef struct packed {
      logic pre_nl2;
      logic pre_indent;
      logic emit_b;
      logic post_space;
      logic post_indent;
      logic eot_indent;
   } plan_type;

   typedef struct packed {
      logic         load_item;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
      logic         cnt_load_pre;
      logic         cnt_load_eot;
      logic         cnt_dec;
   } cmd_type;

   typedef struct packed {
      plan_type plan_now;
      plan_type plan;
      logic     out_free;
      logic     pre_zero;
      logic     eot_zero;
      logic     cnt_one;
   } status_type;

   function automatic logic [DEPTH_W-1:0] sat_inc(input logic [DEPTH_W-1:0] d);
      return (d < MAX_DEPTH) ? d + 1'b1 : d;
   endfunction

   function automatic logic [DEPTH_W-1:0] sat_dec(input logic [DEPTH_W-1:0] d);
      return (d != '0) ? d - 1'b1 : d;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_NL ||
             b == CH_VT || b == CH_FF || b == CH_CR;
   endfunction

endpackage

/* hw/rtl/jpp_datapath.sv */
// Datapath of the JSON pretty printer: parse state, phase plan, indent counter, output register.
module jpp_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_text,
   input  jpp_pkg::cmd_type   cmd,
   output jpp_pkg::status_type st,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last
);
   import jpp_pkg::*;

   logic [DEPTH_W-1:0] depth_ff, depth_in, d1;
   logic               str_ff, str_in;
   logic               esc_ff, esc_in;
   logic               pend_ff, pend_in;
   logic               pair, pend_other, closer;
   plan_type           plan_now, plan_ff;
   logic [DEPTH_W-1:0] level_ff;
   logic [DEPTH_W-1:0] eot_level;
   logic [7:0]         byte_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff;
   logic [7:0]         out_char;

   always_comb begin
      plan_now   = '0;
      str_in     = str_ff;
      esc_in     = esc_ff;
      pend_in    = pend_ff;
      d1         = depth_ff;
      closer     = (req_in_byte == CH_RBRACE) || (req_in_byte == CH_RBRACKET);
      pair       = 1'b0;
      pend_other = 1'b0;
      if (str_ff) begin
         plan_now.emit_b = 1'b1;
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (req_in_byte == CH_BSLASH) begin
            esc_in = 1'b1;
         end else if (req_in_byte == CH_QUOTE) begin
            str_in = 1'b0;
         end
      end else if (!is_space(req_in_byte)) begin
         pair                = pend_ff && closer;
         pend_other          = pend_ff && !closer;
         plan_now.pre_nl2    = pend_ff && (req_in_byte == CH_RBRACKET);
         plan_now.pre_indent = pend_ff || closer;
         plan_now.emit_b     = 1'b1;
         pend_in             = 1'b0;
         if (pend_other) begin
            d1 = sat_inc(depth_ff);
         end
         if (!pair) begin
            case (req_in_byte) inside
               CH_LBRACE, CH_LBRACKET: pend_in = 1'b1;
               CH_RBRACE, CH_RBRACKET: d1 = sat_dec(depth_ff);
               CH_COMMA:               plan_now.post_indent = 1'b1;
               CH_COLON:               plan_now.post_space = 1'b1;
               CH_QUOTE:               str_in = 1'b1;
               default:                ;
            endcase
         end
      end
      plan_now.eot_indent = req_end_of_text && pend_in;
      depth_in = d1;
      if (req_end_of_text) begin
         depth_in = '0;
         str_in   = 1'b0;
         esc_in   = 1'b0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         str_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (cmd.load_item) begin
         depth_ff <= depth_in;
         str_ff   <= str_in;
         esc_ff   <= esc_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         plan_ff  <= plan_now;
         level_ff <= d1;
         byte_ff  <= req_in_byte;
      end
   end

   assign eot_level = sat_inc(level_ff);

   // Space counter: twice the indent level, counted down one space per emission.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_load_pre) begin
         cnt_ff <= {level_ff, 1'b0};
      end else if (cmd.cnt_load_eot) begin
         cnt_ff <= {eot_level, 1'b0};
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.emit_sel)
         SEL_NL:    out_char = CH_NL;
         SEL_SPACE: out_char = CH_SPACE;
         SEL_BYTE:  out_char = byte_ff;
         default:   out_char = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff <= out_char;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   assign st.plan_now = plan_now;
   assign st.plan     = plan_ff;
   assign st.out_free = !out_valid_ff || !rsp_stall;
   assign st.pre_zero = (level_ff == '0);
   assign st.eot_zero = (eot_level == '0);
   assign st.cnt_one  = (cnt_ff == CNT_W'(1));

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= {MAX_DEPTH, 1'b0})
      else $error("indent counter beyond twice the maximum depth");

   a_esc_in_str: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> str_ff)
      else $error("escape flag set outside a string");

   a_pend_not_str: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !str_ff)
      else $error("opener pending while inside a string");

endmodule

/* hw/rtl/jpp_controller.sv */
// Controller of the JSON pretty printer: sequences the output phases of one transaction.
module jpp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  jpp_pkg::status_type st,
   output jpp_pkg::cmd_type    cmd
);
   import jpp_pkg::*;

   localparam logic [2:0] STG_NL2  = 3'd0;
   localparam logic [2:0] STG_PRE  = 3'd1;
   localparam logic [2:0] STG_BYTE = 3'd2;
   localparam logic [2:0] STG_PSP  = 3'd3;
   localparam logic [2:0] STG_PNL  = 3'd4;
   localparam logic [2:0] STG_EOT  = 3'd5;
   localparam logic [2:0] STG_DONE = 3'd6;

   state_type state_ff, state_in;
   state_type nxt;

   // First phase at or after stage k that the plan asks for.
   function automatic state_type first_from(input plan_type p, input logic [2:0] k);
      if (k <= STG_NL2 && p.pre_nl2)     return ST_NL2;
      if (k <= STG_PRE && p.pre_indent)  return ST_PRE_NL;
      if (k <= STG_BYTE && p.emit_b)     return ST_BYTE;
      if (k <= STG_PSP && p.post_space)  return ST_POST_SP;
      if (k <= STG_PNL && p.post_indent) return ST_POST_NL;
      if (k <= STG_EOT && p.eot_indent)  return ST_EOT_NL;
      return ST_IDLE;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      nxt      = ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = first_from(st.plan_now, STG_NL2);
            end
         end
         ST_NL2: begin
            nxt = first_from(st.plan, STG_PRE);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_NL;
               cmd.emit_last = (nxt == ST_IDLE);
               state_in      = nxt;
            end
         end
         ST_PRE_NL: begin
            nxt = first_from(st.plan, STG_BYTE);
            if (st.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_sel     = SEL_NL;
               cmd.cnt_load_pre = 1'b1;
               cmd.emit_last    = st.pre_zero && (nxt == ST_IDLE);
               state_in         = st.pre_zero ? nxt : ST_PRE_SP;
            end
         end
         ST_PRE_SP: begin
            nxt = first_from(st.plan, STG_BYTE);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_SPACE;
               cmd.cnt_dec   = 1'b1;
               cmd.emit_last = st.cnt_one && (nxt == ST_IDLE);
               state_in      = st.cnt_one ? nxt : ST_PRE_SP;
            end
         end
         ST_BYTE: begin
            nxt = first_from(st.plan, STG_PSP);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_BYTE;
               cmd.emit_last = (nxt == ST_IDLE);
               state_in      = nxt;
            end
         end
         ST_POST_SP: begin
            nxt = first_from(st.plan, STG_PNL);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_SPACE;
               cmd.emit_last = (nxt == ST_IDLE);
               state_in      = nxt;
            end
         end
         ST_POST_NL: begin
            nxt = first_from(st.plan, STG_EOT);
            if (st.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_sel     = SEL_NL;
               cmd.cnt_load_pre = 1'b1;
               cmd.emit_last    = st.pre_zero && (nxt == ST_IDLE);
               state_in         = st.pre_zero ? nxt : ST_POST_IND;
            end
         end
         ST_POST_IND: begin
            nxt = first_from(st.plan, STG_EOT);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_SPACE;
               cmd.cnt_dec   = 1'b1;
               cmd.emit_last = st.cnt_one && (nxt == ST_IDLE);
               state_in      = st.cnt_one ? nxt : ST_POST_IND;
            end
         end
         ST_EOT_NL: begin
            nxt = first_from(st.plan, STG_DONE);
            if (st.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_sel     = SEL_NL;
               cmd.cnt_load_eot = 1'b1;
               cmd.emit_last    = st.eot_zero;
               state_in         = st.eot_zero ? nxt : ST_EOT_IND;
            end
         end
         ST_EOT_IND: begin
            nxt = first_from(st.plan, STG_DONE);
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SEL_SPACE;
               cmd.cnt_dec   = 1'b1;
               cmd.emit_last = st.cnt_one;
               state_in      = st.cnt_one ? nxt : ST_EOT_IND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_last |=> state_ff == ST_IDLE)
      else $error("last character emitted but controller did not return to idle");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.out_free)
      else $error("character emitted while the output register was occupied");

endmodule

/* hw/rtl/json_pretty_printer.sv */
// Top level of the streaming JSON pretty printer.
//
//   Channel | Ports                                      | Direction
//   --------+--------------------------------------------+----------
//   request | req_valid, req_stall, req_in_byte,         | in
//           | req_end_of_text                            |
//   response| rsp_valid, rsp_stall, rsp_out_byte,        | out
//           | rsp_run_last                               |
//
// A request transaction is taken only while the controller is idle. Each
// response character then passes through the single output register, which
// the controller fills one character at a time. Whitespace outside strings
// yields no response. Reset is synchronous and active high; it returns the
// controller to idle, clears the nesting depth and parse flags, and empties
// the output register. A stalled response holds its character, and the
// controller waits on it without losing its place in the sequence.
module json_pretty_printer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import jpp_pkg::*;

   // Commands from the controller and status back from the datapath are the
   // only connection between the two halves.
   cmd_type    cmd;
   status_type st;

   // The controller accepts a transaction only when idle, then walks the
   // phases of the plan the datapath worked out at acceptance: extra newline,
   // leading indent, the byte itself, trailing space or indent, and the flush
   // of a pending opener at the end of a document.
   jpp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath keeps the nesting depth and string state, records the plan
   // and indent level of the transaction, counts spaces and drives the
   // response register.
   jpp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .cmd             (cmd),
      .st              (st),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

/* tb/pretty_text_checker.sv */
// Checker for the JSON pretty printer: predicts the formatted characters and compares them.
module pretty_text_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   output int         mismatch_count,
   output int         chars_owed
);
   import jpp_pkg::*;

   localparam int STEP_CHAR_LIMIT = 64;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   // Characters still owed by the block, oldest first.
   out_char_type owed_chars[$];
   out_char_type want;

   logic [DEPTH_W-1:0] nest_depth = '0;
   logic in_quotes  = 1'b0;
   logic escaped    = 1'b0;
   logic open_held  = 1'b0;
   int   step_chars = 0;

   function automatic logic blank(input logic [7:0] b);
      case (b) inside
         CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void clear_state();
      nest_depth = '0;
      in_quotes  = 1'b0;
      escaped    = 1'b0;
      open_held  = 1'b0;
   endfunction

   function automatic void owe(input logic [7:0] ch);
      if (step_chars < STEP_CHAR_LIMIT) begin
         owed_chars.push_back('{ch: ch, last: 1'b0});
         step_chars++;
      end
   endfunction

   function automatic void owe_indent();
      owe(CH_NL);
      for (int i = 0; i < 2 * nest_depth; i++)
         owe(CH_SPACE);
   endfunction

   function automatic void deepen();
      if (nest_depth < MAX_DEPTH)
         nest_depth = nest_depth + 1'b1;
   endfunction

   // Works out every character that one input byte gives rise to.
   function automatic void format_byte(input logic [7:0] b, input logic eot);
      int   base;
      logic paired;
      base       = owed_chars.size();
      step_chars = 0;
      paired     = 1'b0;
      if (in_quotes) begin
         owe(b);
         if (escaped)
            escaped = 1'b0;
         else if (b == CH_BSLASH)
            escaped = 1'b1;
         else if (b == CH_QUOTE)
            in_quotes = 1'b0;
      end else if (!blank(b)) begin
         if (open_held) begin
            open_held = 1'b0;
            if (b == CH_RBRACE) begin
               owe_indent();
               owe(b);
               paired = 1'b1;
            end else if (b == CH_RBRACKET) begin
               owe(CH_NL);
               owe_indent();
               owe(b);
               paired = 1'b1;
            end else begin
               deepen();
               owe_indent();
            end
         end
         if (!paired) begin
            case (b) inside
               CH_LBRACE, CH_LBRACKET: begin
                  owe(b);
                  open_held = 1'b1;
               end
               CH_RBRACE, CH_RBRACKET: begin
                  if (nest_depth != '0)
                     nest_depth = nest_depth - 1'b1;
                  owe_indent();
                  owe(b);
               end
               CH_COMMA: begin
                  owe(b);
                  owe_indent();
               end
               CH_COLON: begin
                  owe(b);
                  owe(CH_SPACE);
               end
               CH_QUOTE: begin
                  owe(b);
                  in_quotes = 1'b1;
               end
               default: owe(b);
            endcase
         end
      end
      if (eot) begin
         if (open_held) begin
            deepen();
            owe_indent();
         end
         clear_state();
      end
      if (owed_chars.size() > base)
         owed_chars[owed_chars.size() - 1].last = 1'b1;
   endfunction

   function automatic void note_mismatch(input string what, input logic [7:0] exp_ch,
                                         input logic exp_last);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected char %h last %b, got char %h last %b", $time, what,
                  exp_ch, exp_last, rsp_out_byte, rsp_run_last);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         owed_chars.delete();
      end else begin
         if (req_valid && !req_stall)
            format_byte(req_in_byte, req_end_of_text);
         if (rsp_valid && !rsp_stall) begin
            if (owed_chars.size() == 0) begin
               note_mismatch("unexpected character", 8'h00, 1'b0);
            end else begin
               want = owed_chars.pop_front();
               if (want.ch !== rsp_out_byte || want.last !== rsp_run_last)
                  note_mismatch("wrong character", want.ch, want.last);
            end
         end
      end
      chars_owed = owed_chars.size();
   end

endmodule

/* tb/tb_top.sv */
// Top of the JSON pretty printer testbench: clock, reset, stimulus and verdict.
module tb_top;
   import jpp_pkg::*;

   // The watchdog ends the run after this many cycles in which no transaction
   // moves on either channel. The long receiver hold-off is far shorter.
   localparam int QUIET_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 6;
   localparam int SETTLE_TIME  = 80;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } text_item_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   int mismatch_count;
   int chars_owed;

   // Bytes waiting to be offered to the block, with their end-of-text flags.
   text_item_type text_q[$];
   int         text_count  = 0;
   int         idle_pct    = 0;
   int         stall_pct   = 0;
   logic       hold_wanted = 1'b0;
   logic       hold_started = 1'b0;
   int         hold_left   = 0;
   int         quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   json_pretty_printer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last)
   );

   pretty_text_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .mismatch_count  (mismatch_count),
      .chars_owed      (chars_owed)
   );

   // The receiver changes its stall at the falling edge. A hold-off request
   // from the stimulus process is raised at a rising edge, so it is seen here
   // without any ordering question, and the hold-off is then counted down in
   // this process alone. Only one long hold-off is made per run.
   always @(negedge clock) begin
      if (hold_wanted && !hold_started) begin
         hold_left    = LONG_HOLD;
         hold_started = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Queues one byte; whitespace is not counted towards the item total, since
   // outside strings the block merely drops it.
   function automatic void add(input logic [7:0] ch, input logic eot);
      text_q.push_back('{ch: ch, eot: eot});
      case (ch) inside
         CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: ;
         default: text_count++;
      endcase
   endfunction

   // Now and then slips a whitespace character of a random kind in between tokens.
   function automatic void add_ws();
      logic [7:0] blanks[6];
      blanks = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
      if ($urandom_range(99) < 15)
         add(blanks[$urandom_range(5)], 1'b0);
   endfunction

   // A quoted string with arbitrary byte values and backslash escapes of any byte.
   function automatic void add_string();
      logic [7:0] c;
      int         n;
      n = $urandom_range(0, 6);
      add(CH_QUOTE, 1'b0);
      repeat (n) begin
         c = 8'($urandom_range(255));
         if ($urandom_range(99) < 20) begin
            add(CH_BSLASH, 1'b0);
            add(c, 1'b0);
         end else begin
            add((c == CH_QUOTE || c == CH_BSLASH) ? 8'h78 : c, 1'b0);
         end
      end
      add(CH_QUOTE, 1'b0);
   endfunction

   function automatic void add_scalar();
      string word;
      case ($urandom_range(3))
         0: add_string();
         1: begin
            if ($urandom_range(1))
               add(8'h2D, 1'b0);
            repeat ($urandom_range(1, 4))
               add(8'h30 + 8'($urandom_range(9)), 1'b0);
         end
         default: begin
            case ($urandom_range(2))
               0: word = "true";
               1: word = "false";
               default: word = "null";
            endcase
            foreach (word[i])
               add(word[i], 1'b0);
         end
      endcase
   endfunction

   function automatic void mark_end();
      text_q[text_q.size() - 1].eot = 1'b1;
   endfunction

   // A well-formed document built by a random walk over nested containers.
   // A small share is cut short, so the end-of-text flag also lands mid-document.
   function automatic void build_document();
      logic [7:0] closers[$];
      bit         fresh[$];
      int         cut;
      closers.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACKET);
      fresh.push_back(1'b1);
      add(closers[$] == CH_RBRACE ? CH_LBRACE : CH_LBRACKET, 1'b0);
      repeat ($urandom_range(1, 6)) begin
         if (closers.size() > 1 && $urandom_range(99) < 25) begin
            add_ws();
            add(closers.pop_back(), 1'b0);
            void'(fresh.pop_back());
         end else begin
            add_ws();
            if (!fresh[$]) begin
               add(CH_COMMA, 1'b0);
               add_ws();
            end
            fresh[$] = 1'b0;
            if (closers[$] == CH_RBRACE) begin
               add_string();
               add_ws();
               add(CH_COLON, 1'b0);
               add_ws();
            end
            if (closers.size() < 5 && $urandom_range(99) < 30) begin
               closers.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACKET);
               fresh.push_back(1'b1);
               add(closers[$] == CH_RBRACE ? CH_LBRACE : CH_LBRACKET, 1'b0);
            end else begin
               add_scalar();
            end
         end
      end
      while (closers.size() > 0) begin
         add_ws();
         add(closers.pop_back(), 1'b0);
      end
      if ($urandom_range(99) < 10) begin
         cut = $urandom_range(1, text_q.size() - 1);
         while (text_q.size() > cut)
            void'(text_q.pop_back());
      end
      mark_end();
   endfunction

   // Nesting around the depth limit, at times beyond it, so the saturation at the top is exercised
   // on the way in and the floor at zero on the way out.
   function automatic void build_deep();
      logic [7:0] closers[$];
      repeat ($urandom_range(13, 18)) begin
         closers.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACKET);
         add(closers[$] == CH_RBRACE ? CH_LBRACE : CH_LBRACKET, 1'b0);
         add_ws();
      end
      if ($urandom_range(1))
         add_scalar();
      while (closers.size() > 0)
         add(closers.pop_back(), 1'b0);
      if ($urandom_range(1))
         add(CH_RBRACKET, 1'b0);
      mark_end();
   endfunction

   // Random bytes with no structure at all.
   function automatic void build_noise();
      int n;
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++)
         add(8'($urandom_range(255)), (i == n - 1) ? 1'($urandom_range(1))
                                                   : ($urandom_range(15) == 0));
   endfunction

   // Offers one transaction from the falling edge and returns at the rising edge
   // at which it is taken. The payload holds still while the block stalls, and
   // valid stays high straight into the next item unless an idle gap is drawn.
   task automatic send_char(input logic [7:0] ch, input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= ch;
      req_end_of_text <= eot;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic send_text();
      text_item_type item;
      while (text_q.size() > 0) begin
         item = text_q.pop_front();
         send_char(item.ch, item.eot);
      end
   endtask

   // The sender stops until every owed character has been delivered, then
   // returns at a rising edge, where the idling rates may safely be changed.
   task automatic drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chars_owed != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      int target;
      int pick;
      idle_plan  = '{0, 46, 0, 26};
      stall_plan = '{0, 0, 46, 26};

      repeat (8)
         @(negedge clock);
      reset <= 1'b0;

      // Directed part, with neither side idling. It covers an empty object and
      // an empty array with whitespace inside, a mismatched empty pair, a closer
      // at depth zero, a string holding an escaped quote, a zero byte and 0xFF,
      // colon and comma, every whitespace kind outside a string, zero and 0xFF
      // outside a string, an end of text that flushes a pending opener, and an
      // end of text that abandons an unterminated string.
      add(CH_LBRACE, 1'b0);
      add(CH_SPACE, 1'b0);
      add(CH_RBRACE, 1'b0);
      add(CH_LBRACKET, 1'b0);
      add(CH_TAB, 1'b0);
      add(CH_RBRACKET, 1'b0);
      add(CH_LBRACE, 1'b0);
      add(CH_RBRACKET, 1'b0);
      add(CH_RBRACKET, 1'b0);
      add(CH_QUOTE, 1'b0);
      add(CH_BSLASH, 1'b0);
      add(CH_QUOTE, 1'b0);
      add(8'h00, 1'b0);
      add(8'hFF, 1'b0);
      add(CH_QUOTE, 1'b0);
      add(CH_COLON, 1'b0);
      add(CH_COMMA, 1'b0);
      add(CH_NL, 1'b0);
      add(CH_CR, 1'b0);
      add(CH_VT, 1'b0);
      add(CH_FF, 1'b0);
      add(8'h00, 1'b0);
      add(8'hFF, 1'b0);
      add(CH_LBRACKET, 1'b1);
      add(CH_QUOTE, 1'b0);
      add(8'h61, 1'b1);
      send_text();
      drain_pause();

      // Back-pressure: the receiver holds off for a long stretch while a deeply
      // nested document keeps arriving, so the block fills up and stalls its
      // input; afterwards the sender waits for every owed character.
      hold_wanted = 1'b1;
      build_deep();
      send_text();
      drain_pause();

      // Random part in four idling phases: none, sender gaps, receiver stalls,
      // and both together.
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         target    = text_count + PHASE_ITEMS;
         while (text_count < target) begin
            pick = $urandom_range(99);
            if (pick < 8)
               build_deep();
            else if (pick < 25)
               build_noise();
            else
               build_document();
            send_text();
         end
         drain_pause();
      end

      // Every owed character has arrived; allow the block time to show any
      // stray output before the verdict.
      repeat (SETTLE_TIME)
         @(posedge clock);
      if (mismatch_count == 0 && chars_owed == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
